// ===== rtl/lspe_pkg.sv =====
// lspe_pkg: shared types, codes and constants of the line sensor position estimator
// no dependencies; imported by lspe_datapath, lspe_ctrl, the core and lspe_checker

package lspe_pkg;

   // fixed geometry of the sensor bar
   localparam int SENSOR_COUNT = 8;
   localparam int CHAN_W       = $clog2(SENSOR_COUNT);
   localparam int KIND_W       = 2;

   // weighted position: sum of weight steps (0..28) times a reciprocal of the count
   localparam int KSUM_W  = 5;
   localparam int RECIP_W = 23;
   localparam int PROD_W  = KSUM_W + RECIP_W;
   localparam int FRAC_W  = 16;
   localparam int QPOS_W  = 10;
   localparam int POS_W   = 11;
   localparam int SEEN_W  = 4;

   // result transaction: position, line bits, seen count, padded to bytes
   localparam int OUT_RAW_W = POS_W + SENSOR_COUNT + SEEN_W;
   localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

   // position limits
   localparam logic signed [POS_W-1:0] POS_LOST      = -11'sd1;
   localparam logic signed [POS_W-1:0] POS_LEFT      = 11'sd0;
   localparam logic signed [POS_W-1:0] POS_RIGHT     = 11'sd700;
   localparam logic signed [POS_W-1:0] EDGE_LOW      = 11'sd100;
   localparam logic signed [POS_W-1:0] EDGE_HIGH     = 11'sd600;

   // configuration register index (word address bit)
   localparam logic CSR_IDX_POLARITY = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_MEASURE    = 2'd0,
      KIND_BACKGROUND = 2'd1,
      KIND_LINE       = 2'd2,
      KIND_FINISH     = 2'd3
   } kind_type;

   // controller to datapath commands
   typedef struct packed {
      logic              load;
      logic              acc_bg;
      logic              acc_line;
      logic              meas_bits;
      logic              meas_mult;
      logic              emit;
      logic              div_start;
      logic              div_line;
      logic              store_bg;
      logic              store_thr;
      logic              clear_cal;
      logic [CHAN_W-1:0] chan;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

   // ceil(100 * 2^16 / count); exact floor(100*k/count) for k <= 28
   function automatic logic [RECIP_W-1:0] recip_of(input logic [SEEN_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 23'd6553600;
         4'd2:    r = 23'd3276800;
         4'd3:    r = 23'd2184534;
         4'd4:    r = 23'd1638400;
         4'd5:    r = 23'd1310720;
         4'd6:    r = 23'd1092267;
         4'd7:    r = 23'd936229;
         4'd8:    r = 23'd819200;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/lspe_div.sv =====
// lspe_div: restoring divider, one quotient bit per cycle
// depends on nothing; used by lspe_datapath for the calibration averages

module lspe_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;

   // operand load on start, else one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/lspe_datapath.sv =====
// lspe_datapath: calibration sums, thresholds, measure pipeline and result register
// depends on lspe_pkg and lspe_div; driven by lspe_ctrl through cmd_type

module lspe_datapath #(
   parameter int MAX_SCANS   = 1024,
   parameter int SAMPLE_BITS = 10,
   parameter int IN_W        = 80
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lspe_pkg::cmd_type      cmd,
   output lspe_pkg::status_type   status,
   input  logic                   polarity,
   input  logic [IN_W-1:0]        req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [lspe_pkg::OUT_W-1:0] rsp_tdata
);
   import lspe_pkg::*;

   localparam int CNT_W = $clog2(MAX_SCANS + 1);
   localparam int SUM_W = SAMPLE_BITS + CNT_W;

   logic [SAMPLE_BITS-1:0] samp_ff [SENSOR_COUNT];
   logic [SUM_W-1:0]       bg_sum_ff [SENSOR_COUNT];
   logic [SUM_W-1:0]       ln_sum_ff [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0] thr_ff [SENSOR_COUNT];
   logic [CNT_W-1:0]       bg_cnt_ff, ln_cnt_ff;
   logic [SAMPLE_BITS-1:0] bavg_ff;
   logic signed [POS_W-1:0] last_pos_ff;

   logic [SENSOR_COUNT-1:0] bits1_ff, bits2_ff, bits_in;
   logic [SEEN_W-1:0]       seen1_ff, seen2_ff, seen_in;
   logic [KSUM_W-1:0]       ksum_ff, ksum_in;
   logic [PROD_W-1:0]       prod_ff;

   logic                    out_valid_ff;
   logic [OUT_W-1:0]        out_data_ff;
   logic signed [POS_W-1:0] pos_in;

   logic                    div_done;
   logic [SUM_W-1:0]        div_quo;
   logic [SUM_W-1:0]        div_num;
   logic [CNT_W-1:0]        div_den;
   logic [SAMPLE_BITS-1:0]  avg_in;
   logic [SAMPLE_BITS:0]    mid_sum;

   // shared divider for the channel averages
   assign div_num = cmd.div_line ? ln_sum_ff[cmd.chan] : bg_sum_ff[cmd.chan];
   assign div_den = cmd.div_line ? ln_cnt_ff : bg_cnt_ff;

   lspe_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // average is zero when no scan of that kind was taken
   always_comb begin
      avg_in = div_quo[SAMPLE_BITS-1:0];
      if (div_den == '0) begin
         avg_in = '0;
      end
      mid_sum = {1'b0, bavg_ff} + {1'b0, avg_in};
   end

   // line bits, seen count and weight-step sum
   always_comb begin
      logic above;
      bits_in = '0;
      seen_in = '0;
      ksum_in = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         above = samp_ff[i] > thr_ff[i];
         if (polarity ? !above : above) begin
            bits_in[i] = 1'b1;
            seen_in    = seen_in + 1'b1;
            ksum_in    = ksum_in + KSUM_W'(SENSOR_COUNT - 1 - i);
         end
      end
   end

   // final position, with edge hold when the line is lost
   always_comb begin
      if (seen2_ff != '0) begin
         pos_in = signed'({1'b0, prod_ff[FRAC_W +: QPOS_W]});
      end else begin
         pos_in = POS_LOST;
         if (last_pos_ff <= EDGE_LOW) begin
            pos_in = POS_LEFT;
         end
         if (last_pos_ff >= EDGE_HIGH) begin
            pos_in = POS_RIGHT;
         end
      end
   end

   // calibration state and last position
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            bg_sum_ff[i] <= '0;
            ln_sum_ff[i] <= '0;
            thr_ff[i]    <= '0;
         end
         bg_cnt_ff   <= '0;
         ln_cnt_ff   <= '0;
         last_pos_ff <= '0;
      end else begin
         if (cmd.acc_bg && bg_cnt_ff < CNT_W'(MAX_SCANS)) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               bg_sum_ff[i] <= bg_sum_ff[i] + SUM_W'(samp_ff[i]);
            end
            bg_cnt_ff <= bg_cnt_ff + 1'b1;
         end
         if (cmd.acc_line && ln_cnt_ff < CNT_W'(MAX_SCANS)) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               ln_sum_ff[i] <= ln_sum_ff[i] + SUM_W'(samp_ff[i]);
            end
            ln_cnt_ff <= ln_cnt_ff + 1'b1;
         end
         if (cmd.store_thr) begin
            thr_ff[cmd.chan] <= mid_sum[SAMPLE_BITS:1];
         end
         if (cmd.clear_cal) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               bg_sum_ff[i] <= '0;
               ln_sum_ff[i] <= '0;
            end
            bg_cnt_ff <= '0;
            ln_cnt_ff <= '0;
         end
         if (cmd.emit) begin
            last_pos_ff <= pos_in;
         end
      end
   end

   // input capture, measure pipeline and background average
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            samp_ff[i] <= req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
         end
      end
      if (cmd.meas_bits) begin
         bits1_ff <= bits_in;
         seen1_ff <= seen_in;
         ksum_ff  <= ksum_in;
      end
      if (cmd.meas_mult) begin
         bits2_ff <= bits1_ff;
         seen2_ff <= seen1_ff;
         prod_ff  <= PROD_W'(ksum_ff) * PROD_W'(recip_of(seen1_ff));
      end
      if (cmd.store_bg) begin
         bavg_ff <= avg_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_data_ff <= OUT_W'({seen2_ff, bits2_ff, pos_in});
      end
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_data_ff;
   assign status.div_done = div_done;
   assign status.out_free = !out_valid_ff || rsp_tready;

endmodule

// ===== rtl/lspe_ctrl.sv =====
// lspe_ctrl: sequencer for scans, measurements and the calibration finish
// depends on lspe_pkg; commands lspe_datapath through cmd_type

module lspe_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lspe_pkg::KIND_W-1:0]   req_tuser,
   output lspe_pkg::cmd_type             cmd,
   input  lspe_pkg::status_type          status
);
   import lspe_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_BG,
      ST_ACC_LINE,
      ST_MEAS_BITS,
      ST_MEAS_MULT,
      ST_MEAS_EMIT,
      ST_FIN_BG_GO,
      ST_FIN_BG_WAIT,
      ST_FIN_LINE_GO,
      ST_FIN_LINE_WAIT,
      ST_FIN_CLEAR
   } state_type;

   state_type         state_ff, state_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic              accept;
   kind_type          kind;

   assign accept     = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      cmd      = '0;
      cmd.chan = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) begin
               chan_in = '0;
               case (kind)
                  KIND_MEASURE:    state_in = ST_MEAS_BITS;
                  KIND_BACKGROUND: state_in = ST_ACC_BG;
                  KIND_LINE:       state_in = ST_ACC_LINE;
                  KIND_FINISH:     state_in = ST_FIN_BG_GO;
                  default:         state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACC_BG: begin
            cmd.acc_bg = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_ACC_LINE: begin
            cmd.acc_line = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_MEAS_BITS: begin
            cmd.meas_bits = 1'b1;
            state_in      = ST_MEAS_MULT;
         end
         ST_MEAS_MULT: begin
            cmd.meas_mult = 1'b1;
            state_in      = ST_MEAS_EMIT;
         end
         ST_MEAS_EMIT: begin
            // wait for room in the result register
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FIN_BG_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_FIN_BG_WAIT;
         end
         ST_FIN_BG_WAIT: begin
            if (status.div_done) begin
               cmd.store_bg = 1'b1;
               state_in     = ST_FIN_LINE_GO;
            end
         end
         ST_FIN_LINE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_line  = 1'b1;
            state_in      = ST_FIN_LINE_WAIT;
         end
         ST_FIN_LINE_WAIT: begin
            cmd.div_line = 1'b1;
            if (status.div_done) begin
               cmd.store_thr = 1'b1;
               if (chan_ff == CHAN_W'(SENSOR_COUNT - 1)) begin
                  state_in = ST_FIN_CLEAR;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_FIN_BG_GO;
               end
            end
         end
         ST_FIN_CLEAR: begin
            cmd.clear_cal = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and channel counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

// ===== rtl/line_sensor_position_estimator_core.sv =====
// Line sensor position estimator. Each req transaction is one scan of eight samples
// (req_tdata, sensor 0 in the lowest bits) with its kind on req_tuser. A measure scan
// registers its line bits, then its scaled product, and writes the rsp register once
// that register is free, stalling while the sink still holds the previous result;
// background and line scans give no result. No new scan is accepted before the last
// one is done. A finish transaction runs the shared one-bit-per-cycle divider over the
// sixteen channel averages, during which no scan is accepted. The user must write
// polarity at byte address 0 of the csr port while the block is idle; the block itself
// does not enforce this.
// depends on lspe_pkg, lspe_ctrl, lspe_datapath and lspe_div

module line_sensor_position_estimator_core #(
   parameter int MAX_SCANS   = 1024,
   parameter int SAMPLE_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   // request: tdata = sample_0 .. sample_7, SAMPLE_BITS each, zero padded to bytes
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   input  logic [((lspe_pkg::SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // request: tuser = kind
   input  logic [lspe_pkg::KIND_W-1:0]                    req_tuser,
   // response: tdata = position[10:0], line_bits[18:11], seen_count[22:19], zero pad
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   output logic [lspe_pkg::OUT_W-1:0]                     rsp_tdata,
   // configuration
   input  logic                                           csr_psel,
   input  logic                                           csr_penable,
   input  logic                                           csr_pwrite,
   input  logic [2:0]                                     csr_paddr,
   input  logic [31:0]                                    csr_pwdata,
   output logic [31:0]                                    csr_prdata,
   output logic                                           csr_pready
);
   import lspe_pkg::*;

   localparam int IN_W = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;

   cmd_type    cmd;
   status_type status;
   logic       polarity_ff;

   // polarity register
   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == CSR_IDX_POLARITY) begin
         polarity_ff <= csr_pwdata[0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_POLARITY) ? {31'b0, polarity_ff} : '0;

   lspe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   lspe_datapath #(
      .MAX_SCANS   (MAX_SCANS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IN_W        (IN_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .polarity   (polarity_ff),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/lspe_checker.sv =====
// lspe_checker: port-level checks of the line sensor position estimator
// depends on lspe_pkg; bound to line_sensor_position_estimator_core below

module lspe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [lspe_pkg::OUT_W-1:0]   rsp_tdata,
   input logic                         csr_pready
);
   import lspe_pkg::*;

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // seen count matches the line bits
   a_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:19] == 4'($countones(rsp_tdata[18:11])))
      else $error("seen count differs from line bits");

   // a lost line reports only the lost code or an edge
   a_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22:19] == 4'd0 |->
         rsp_tdata[10:0] == POS_LOST || rsp_tdata[10:0] == POS_LEFT
         || rsp_tdata[10:0] == POS_RIGHT)
      else $error("lost line with a bad position");

   // the csr port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr port not ready");

endmodule

bind line_sensor_position_estimator_core lspe_checker u_lspe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
